/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules of the cipher round.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/idea_pkg.sv */
// Shared types and modular arithmetic helpers for the cipher round pipeline.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package idea_pkg;

    localparam int WORD_W = 16;

    typedef logic [WORD_W-1:0] word_t;

    // Multiplier half-result: raw product plus what the zero-operand case needs.
    typedef struct packed {
        logic [2*WORD_W-1:0] prod;
        logic                zero;   // an operand stood for 65536
        word_t               other;  // the operand that is not that one
    } mul_t;

    typedef struct packed {
        word_t       a;
        word_t       b;
        word_t       c;
        word_t       d;
        logic [63:0] keys_front;
        logic [31:0] keys_mix;
        logic [63:0] keys_out;
        logic        fin;
    } blk_in_t;

    // After stage 1: first-layer products and sums.
    typedef struct packed {
        mul_t        m0;
        word_t       y1;
        word_t       y2;
        mul_t        m3;
        logic [31:0] keys_mix;
        logic [63:0] keys_out;
        logic        fin;
    } st1_t;

    // After stage 2: first layer reduced, product with subkey five started.
    typedef struct packed {
        word_t       y0;
        word_t       y1;
        word_t       y2;
        word_t       y3;
        mul_t        ms;
        word_t       k6;
        logic [63:0] keys_out;
        logic        fin;
    } st2_t;

    // After stage 3: s known, product with subkey six started.
    typedef struct packed {
        word_t       y0;
        word_t       y1;
        word_t       y2;
        word_t       y3;
        word_t       s;
        mul_t        mt;
        logic [63:0] keys_out;
        logic        fin;
    } st3_t;

    // After stage 4: mixed words plus output transform products.
    typedef struct packed {
        word_t w0;
        word_t w1;
        word_t w2;
        word_t w3;
        mul_t  m0;
        word_t v1;
        word_t v2;
        mul_t  m3;
        logic  fin;
    } st4_t;

    // Start a multiply modulo 65537; word 0 stands for 65536.
    function automatic mul_t mul_start(input word_t x, input word_t y);
        mul_t r;
        r.prod  = {{WORD_W{1'b0}}, x} * {{WORD_W{1'b0}}, y};
        r.zero  = (x == '0) || (y == '0);
        r.other = (x == '0) ? y : x;
        return r;
    endfunction

    // Finish the multiply: low half minus high half, with end-around fix.
    function automatic word_t mul_finish(input mul_t m);
        word_t lo;
        word_t hi;
        word_t r;
        lo = m.prod[WORD_W-1:0];
        hi = m.prod[2*WORD_W-1:WORD_W];
        if (m.zero) begin
            r = word_t'(1) - m.other;
        end else begin
            r = lo - hi + {{(WORD_W-1){1'b0}}, (lo < hi)};
        end
        return r;
    endfunction

endpackage

/* rtl/idea_front.sv */
// Stages 1 and 2: key layer on the four words and start of the mixing product.
// Depends on idea_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module idea_front
    import idea_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  blk_in_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output st2_t    out_data
);

    logic st1_valid_reg;
    logic st2_valid_reg;
    st1_t st1_reg;
    st1_t st1_next;
    st2_t st2_reg;
    st2_t st2_next;
    logic st1_ready;
    logic st2_ready;

    assign st2_ready = !st2_valid_reg || out_ready;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign in_ready  = st1_ready;
    assign out_valid = st2_valid_reg;
    assign out_data  = st2_reg;

    always_comb begin
        st1_next.m0       = mul_start(in_data.a, in_data.keys_front[63:48]);
        st1_next.y1       = in_data.b + in_data.keys_front[47:32];
        st1_next.y2       = in_data.c + in_data.keys_front[31:16];
        st1_next.m3       = mul_start(in_data.d, in_data.keys_front[15:0]);
        st1_next.keys_mix = in_data.keys_mix;
        st1_next.keys_out = in_data.keys_out;
        st1_next.fin      = in_data.fin;
    end

    always_comb begin
        st2_next.y0       = mul_finish(st1_reg.m0);
        st2_next.y1       = st1_reg.y1;
        st2_next.y2       = st1_reg.y2;
        st2_next.y3       = mul_finish(st1_reg.m3);
        st2_next.ms       = mul_start(st2_next.y0 ^ st2_next.y2, st1_reg.keys_mix[31:16]);
        st2_next.k6       = st1_reg.keys_mix[15:0];
        st2_next.keys_out = st1_reg.keys_out;
        st2_next.fin      = st1_reg.fin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            if (st1_ready) begin
                st1_valid_reg <= in_valid;
            end
            if (st2_ready) begin
                st2_valid_reg <= st1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_ready && in_valid) begin
            st1_reg <= st1_next;
        end
        if (st2_ready && st1_valid_reg) begin
            st2_reg <= st2_next;
        end
    end

    // Back pressure only reaches the input once both stages are full.
    `ASSERT_IMPL(a_full_when_blocked, aclk, aresetn, !in_ready, st1_valid_reg && st2_valid_reg)
    // A stalled item in stage 2 holds its contents.
    `ASSERT_NEXT(a_st2_hold, aclk, aresetn, st2_valid_reg && !out_ready,
                 st2_valid_reg && $stable(st2_reg))
    // An accepted request always lands in stage 1.
    `ASSERT_NEXT(a_st1_load, aclk, aresetn, in_valid && in_ready, st1_valid_reg)

endmodule

/* rtl/idea_mix.sv */
// Stages 3 and 4: multiply-add mixing step and start of the output transform.
// Depends on idea_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module idea_mix
    import idea_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  st2_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output st4_t out_data
);

    logic  st3_valid_reg;
    logic  st4_valid_reg;
    st3_t  st3_reg;
    st3_t  st3_next;
    st4_t  st4_reg;
    st4_t  st4_next;
    logic  st3_ready;
    logic  st4_ready;
    word_t s_val;
    word_t t_val;
    word_t s_sum;

    assign st4_ready = !st4_valid_reg || out_ready;
    assign st3_ready = !st3_valid_reg || st4_ready;
    assign in_ready  = st3_ready;
    assign out_valid = st4_valid_reg;
    assign out_data  = st4_reg;

    always_comb begin
        s_val             = mul_finish(in_data.ms);
        st3_next.y0       = in_data.y0;
        st3_next.y1       = in_data.y1;
        st3_next.y2       = in_data.y2;
        st3_next.y3       = in_data.y3;
        st3_next.s        = s_val;
        st3_next.mt       = mul_start((in_data.y1 ^ in_data.y3) + s_val, in_data.k6);
        st3_next.keys_out = in_data.keys_out;
        st3_next.fin      = in_data.fin;
    end

    always_comb begin
        t_val       = mul_finish(st3_reg.mt);
        s_sum       = st3_reg.s + t_val;
        st4_next.w0 = st3_reg.y0 ^ t_val;
        st4_next.w1 = st3_reg.y1 ^ s_sum;
        st4_next.w2 = st3_reg.y2 ^ t_val;
        st4_next.w3 = st3_reg.y3 ^ s_sum;
        st4_next.m0 = mul_start(st4_next.w0, st3_reg.keys_out[63:48]);
        st4_next.v1 = st4_next.w1 + st3_reg.keys_out[47:32];
        st4_next.v2 = st4_next.w2 + st3_reg.keys_out[31:16];
        st4_next.m3 = mul_start(st4_next.w3, st3_reg.keys_out[15:0]);
        st4_next.fin = st3_reg.fin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
        end else begin
            if (st3_ready) begin
                st3_valid_reg <= in_valid;
            end
            if (st4_ready) begin
                st4_valid_reg <= st3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st3_ready && in_valid) begin
            st3_reg <= st3_next;
        end
        if (st4_ready && st3_valid_reg) begin
            st4_reg <= st4_next;
        end
    end

    `ASSERT_IMPL(a_full_when_blocked, aclk, aresetn, !in_ready, st3_valid_reg && st4_valid_reg)
    `ASSERT_NEXT(a_st4_hold, aclk, aresetn, st4_valid_reg && !out_ready,
                 st4_valid_reg && $stable(st4_reg))
    `ASSERT_NEXT(a_st3_load, aclk, aresetn, in_valid && in_ready, st3_valid_reg)

endmodule

/* rtl/idea_out.sv */
// Stage 5: finish the output transform or swap, and hold the result register.
// Depends on idea_pkg.
`timescale 1ns / 1ps

module idea_out
    import idea_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  st4_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output word_t out_a,
    output word_t out_b,
    output word_t out_c,
    output word_t out_d
);

    logic  res_valid_reg;
    word_t res_a_reg;
    word_t res_b_reg;
    word_t res_c_reg;
    word_t res_d_reg;
    word_t res_a_next;
    word_t res_b_next;
    word_t res_c_next;
    word_t res_d_next;
    logic  res_ready;

    assign res_ready = !res_valid_reg || out_ready;
    assign in_ready  = res_ready;
    assign out_valid = res_valid_reg;
    assign out_a     = res_a_reg;
    assign out_b     = res_b_reg;
    assign out_c     = res_c_reg;
    assign out_d     = res_d_reg;

    always_comb begin
        if (in_data.fin) begin
            res_a_next = mul_finish(in_data.m0);
            res_b_next = in_data.v1;
            res_c_next = in_data.v2;
            res_d_next = mul_finish(in_data.m3);
        end else begin
            // normal round: swap the middle words
            res_a_next = in_data.w0;
            res_b_next = in_data.w2;
            res_c_next = in_data.w1;
            res_d_next = in_data.w3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (res_ready) begin
            res_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && in_valid) begin
            res_a_reg <= res_a_next;
            res_b_reg <= res_b_next;
            res_c_reg <= res_c_next;
            res_d_reg <= res_d_next;
        end
    end

endmodule

/* rtl/idea_round.sv */
// One IDEA cipher round as a five-stage stream pipeline: one block per clock while
// m_tready holds, with the stages following the chain of four dependent
// modulo-65537 multiplies, each split into a 16x16 product stage and a
// reduction that feeds the next product. A request carries the four data words
// and all ten subkeys; final_round on s_tuser applies the output transform
// with subkeys seven to ten instead of the middle-word swap. Zero stands for
// 65536 in every multiply, so zero times zero yields one. There is no stored
// state and no configuration; every stage has a valid bit and its own ready,
// so stalls on m_tready hold data in place and bubbles close up behind them.
// Depends on idea_pkg, idea_front, idea_mix and idea_out.
`timescale 1ns / 1ps

module idea_round
    import idea_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // word_a, word_b, word_c, word_d, subkeys_front, subkeys_mix, subkeys_output
    input  logic [223:0] s_tdata,
    // final_round
    input  logic         s_tuser,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_a, out_b, out_c, out_d
    output logic [63:0]  m_tdata
);

    blk_in_t req;
    st2_t    front_data;
    logic    front_valid;
    logic    mix_ready;
    st4_t    mix_data;
    logic    mix_valid;
    logic    out_ready_int;

    // Unpack the request: fields sit from the lowest bit up.
    always_comb begin
        req.a          = s_tdata[15:0];
        req.b          = s_tdata[31:16];
        req.c          = s_tdata[47:32];
        req.d          = s_tdata[63:48];
        req.keys_front = s_tdata[127:64];
        req.keys_mix   = s_tdata[159:128];
        req.keys_out   = s_tdata[223:160];
        req.fin        = s_tuser;
    end

    // Stages 1-2: key layer, then start the subkey-five product.
    idea_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (req),
        .out_valid (front_valid),
        .out_ready (mix_ready),
        .out_data  (front_data)
    );

    // Stages 3-4: finish the multiply-add structure, start output products.
    idea_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (mix_ready),
        .in_data   (front_data),
        .out_valid (mix_valid),
        .out_ready (out_ready_int),
        .out_data  (mix_data)
    );

    // Stage 5: select transform or swap, hold the result until taken.
    idea_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mix_valid),
        .in_ready  (out_ready_int),
        .in_data   (mix_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_a     (m_tdata[15:0]),
        .out_b     (m_tdata[31:16]),
        .out_c     (m_tdata[47:32]),
        .out_d     (m_tdata[63:48])
    );

endmodule

/* tb/sv/idea_round_checker.sv */
// Scoreboard for the cipher round stream: watches both channels, predicts each block.
// Compares every result against the oldest prediction; depends on idea_pkg only.
`timescale 1ns / 1ps

module idea_round_checker
    import idea_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [223:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    output int           fail_count,
    output int           blocks_in_flight
);

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } block_t;

    block_t expected_blocks[$];

    initial begin
        fail_count       = 0;
        blocks_in_flight = 0;
    end

    // Multiply modulo 65537 with zero standing for 65536.
    function automatic word_t mul_mod65537(input word_t x, input word_t y);
        longint unsigned p;
        longint unsigned q;
        p = (x == '0) ? 64'd65536 : 64'(x);
        q = (y == '0) ? 64'd65536 : 64'(y);
        return word_t'((p * q) % 64'd65537);
    endfunction

    function automatic block_t cipher_round(input logic [223:0] req, input logic last_round);
        word_t       x0;
        word_t       x1;
        word_t       x2;
        word_t       x3;
        word_t       s;
        word_t       t;
        logic [63:0] kf;
        logic [31:0] km;
        logic [63:0] ko;
        block_t      r;
        x0 = req[15:0];
        x1 = req[31:16];
        x2 = req[47:32];
        x3 = req[63:48];
        kf = req[127:64];
        km = req[159:128];
        ko = req[223:160];
        x0 = mul_mod65537(x0, kf[63:48]);
        x1 = x1 + kf[47:32];
        x2 = x2 + kf[31:16];
        x3 = mul_mod65537(x3, kf[15:0]);
        s  = mul_mod65537(x0 ^ x2, km[31:16]);
        t  = mul_mod65537((x1 ^ x3) + s, km[15:0]);
        s  = s + t;
        x0 = x0 ^ t;
        x2 = x2 ^ t;
        x1 = x1 ^ s;
        x3 = x3 ^ s;
        if (last_round) begin
            r.a = mul_mod65537(x0, ko[63:48]);
            r.b = x1 + ko[47:32];
            r.c = x2 + ko[31:16];
            r.d = mul_mod65537(x3, ko[15:0]);
        end else begin
            r.a = x0;
            r.b = x2;
            r.c = x1;
            r.d = x3;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("[%0t] mismatch on %s: got %04h, expected %04h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        block_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[15:0], '0);
                end else begin
                    want = expected_blocks.pop_front();
                    if (m_tdata[15:0] !== want.a) report_mismatch("out_a", m_tdata[15:0], want.a);
                    if (m_tdata[31:16] !== want.b) report_mismatch("out_b", m_tdata[31:16], want.b);
                    if (m_tdata[47:32] !== want.c) report_mismatch("out_c", m_tdata[47:32], want.c);
                    if (m_tdata[63:48] !== want.d) report_mismatch("out_d", m_tdata[63:48], want.d);
                end
            end
            if (s_tvalid && s_tready)
                expected_blocks.push_back(cipher_round(s_tdata, s_tuser));
        end
        blocks_in_flight <= expected_blocks.size();
    end

endmodule

/* tb/sv/idea_round_tb.sv */
// Top of the cipher round testbench: clock, reset, request stimulus and verdict.
// Depends on idea_pkg, idea_round and idea_round_checker.
`timescale 1ns / 1ps

module idea_round_tb;
    import idea_pkg::*;

    localparam int RANDOM_BLOCKS = 1650;
    localparam int PHASES        = 3;
    localparam int DRAIN_CYCLES  = 20;       // pipeline is five stages deep
    localparam int CYCLE_LIMIT   = 200000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;

    int fail_count;
    int blocks_in_flight;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;

    idea_round u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    idea_round_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .fail_count       (fail_count),
        .blocks_in_flight (blocks_in_flight)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: drop m_tready at random, at the rate the current phase asks.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: give up if the run hangs.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Pack one request: data words in the low 64 bits, then the three subkey groups.
    function automatic logic [223:0] pack_request(input word_t a, input word_t b,
                                                  input word_t c, input word_t d,
                                                  input logic [63:0] front,
                                                  input logic [31:0] mix,
                                                  input logic [63:0] outk);
        return {outk, mix, front, d, c, b, a};
    endfunction

    // Bias toward the multiply corner cases: zero (65536), one, all ones, half scale.
    function automatic word_t pick_word();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'hFFFF;
            3:       return 16'h8000;
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_keys4();
        return {pick_word(), pick_word(), pick_word(), pick_word()};
    endfunction

    // Present one request, idling first at the phase rate; return once it is taken.
    task automatic send_block(input logic [223:0] req, input logic last_round);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        s_tuser  <= last_round;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off requests until every predicted block has come back.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (blocks_in_flight != 0) @(posedge aclk);
    endtask

    task automatic send_random_block();
        send_block(pack_request(pick_word(), pick_word(), pick_word(), pick_word(),
                                pick_keys4(), {pick_word(), pick_word()}, pick_keys4()),
                   1'($urandom_range(1)));
    endtask

    initial begin
        int send_pct[PHASES];
        int recv_pct[PHASES];
        send_pct = '{19, 56, 0};
        recv_pct = '{56, 19, 0};
        send_idle_pct = send_pct[0];
        recv_idle_pct = recv_pct[0];
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed blocks: all zero words and keys hit zero times zero in the first layer.
        send_block(pack_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, '0, '0, '0), 1'b0);
        send_block(pack_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, '0, '0, '0), 1'b1);
        send_block(pack_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                '1, '1, '1), 1'b0);
        send_block(pack_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                '1, '1, '1), 1'b1);
        send_block(pack_request(16'h0001, 16'h0001, 16'h0001, 16'h0001,
                                {4{16'h0001}}, {2{16'h0001}}, {4{16'h0001}}), 1'b1);
        // Products that land on 65536 and come back as word zero.
        send_block(pack_request(16'h0002, 16'h1234, 16'h5678, 16'h8000,
                                {16'h8000, 16'h0000, 16'h0000, 16'h0002},
                                {16'h8000, 16'h0002}, {16'h8000, 16'h0000, 16'h0000, 16'h0002}),
                   1'b1);
        send_block(pack_request(16'h0001, 16'h0000, 16'h0000, 16'h0000,
                                {16'h0000, 16'h0000, 16'h0000, 16'h0001},
                                {16'h0001, 16'h0000}, {16'h0001, 16'h0000, 16'h0000, 16'h0000}),
                   1'b1);
        // Identical data: two normal rounds ignore opposite output subkeys, then a final round.
        send_block(pack_request(16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0,
                                64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF, '0), 1'b0);
        send_block(pack_request(16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0,
                                64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF, '1), 1'b0);
        send_block(pack_request(16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0,
                                64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF,
                                64'hFEDC_BA98_7654_3210), 1'b1);
        repeat (8) send_random_block();

        // Let the pipeline empty completely once before the random traffic.
        drain_pipeline();

        for (int phase = 0; phase < PHASES; phase++) begin
            send_idle_pct = send_pct[phase];
            recv_idle_pct = recv_pct[phase];
            for (int n = 0; n < RANDOM_BLOCKS / PHASES; n++)
                send_random_block();
        end

        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* idea_round.f */
+incdir+rtl
rtl/idea_pkg.sv
rtl/idea_front.sv
rtl/idea_mix.sv
rtl/idea_out.sv
rtl/idea_round.sv
tb/sv/idea_round_checker.sv
tb/sv/idea_round_tb.sv
